>>> src/assert_macros.svh
// Assertion helpers shared by the classifier's counter and scale modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FPWC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FPWC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> src/fpwc_pkg.sv
`default_nettype none

package fpwc_pkg;

   localparam int GapWidth     = 20;
   localparam int WindowWidth  = 24;
   localparam int CountWidth   = 16;
   localparam int ScaleWidth   = 32;
   localparam int FlowWidth    = 16;
   localparam int ClassWidth   = 2;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 32;
   localparam int FracBits     = 16;
   localparam int ProdWidth    = CountWidth + ScaleWidth;

   localparam logic [GapWidth-1:0]    GapMax     = '1;
   localparam logic [WindowWidth-1:0] ElapsedMax = '1;
   localparam logic [CountWidth-1:0]  CountMax   = '1;
   localparam logic [FlowWidth-1:0]   FlowMax    = '1;

   localparam logic [GapWidth-1:0]    RstMinPulseGap   = 20'd1000;
   localparam logic [WindowWidth-1:0] RstWindowLen     = 24'd400000;
   localparam logic [CountWidth-1:0]  RstMinValidCount = 16'd2;
   localparam logic [ScaleWidth-1:0]  RstFlowScale     = 32'd2184533;
   localparam logic [FlowWidth-1:0]   RstThrNoFlow     = 16'd30;
   localparam logic [FlowWidth-1:0]   RstThrMedium     = 16'd700;
   localparam logic [FlowWidth-1:0]   RstThrStrong     = 16'd1600;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MIN_PULSE_GAP   = 3'd0,
      CSR_WINDOW_LEN      = 3'd1,
      CSR_MIN_VALID_COUNT = 3'd2,
      CSR_FLOW_SCALE      = 3'd3,
      CSR_THR_NO_FLOW     = 3'd4,
      CSR_THR_MEDIUM      = 3'd5,
      CSR_THR_STRONG      = 3'd6
   } csr_index_type;

   typedef enum logic [ClassWidth-1:0] {
      CLASS_NO_FLOW = 2'd0,
      CLASS_WEAK    = 2'd1,
      CLASS_MEDIUM  = 2'd2,
      CLASS_STRONG  = 2'd3
   } flow_class_type;

   typedef struct packed {
      logic [GapWidth-1:0]    min_pulse_gap;
      logic [WindowWidth-1:0] window_len;
      logic [CountWidth-1:0]  min_valid_count;
      logic [ScaleWidth-1:0]  flow_scale;
      logic [FlowWidth-1:0]   thr_no_flow;
      logic [FlowWidth-1:0]   thr_medium;
      logic [FlowWidth-1:0]   thr_strong;
   } cfg_type;

   // Closed window, after the minimum count check.
   typedef struct packed {
      logic [CountWidth-1:0] count;
   } win_type;

   // Scaled and saturated flow with the count that produced it.
   typedef struct packed {
      logic [FlowWidth-1:0]  flow;
      logic [CountWidth-1:0] count;
   } flow_type;

endpackage

`default_nettype wire

>>> src/fpwc_counter.sv
`default_nettype none

module fpwc_counter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fpwc_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic             in_rise,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output fpwc_pkg::win_type     out_win
);
   import fpwc_pkg::*;

   `include "assert_macros.svh"

   logic [CountWidth-1:0]  pulses_ff,  pulses_in;
   logic [GapWidth-1:0]    gap_ff,     gap_in;
   logic [WindowWidth-1:0] elapsed_ff, elapsed_in;
   logic                   valid_ff;
   win_type                win_ff;
   logic                   accept;
   logic                   counted;
   logic                   closing;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      counted = in_rise && (gap_ff >= cfg.min_pulse_gap);
      if (counted) begin
         pulses_in = (pulses_ff != CountMax) ? pulses_ff + 1'b1 : pulses_ff;
         gap_in    = GapWidth'(1);
      end else begin
         pulses_in = pulses_ff;
         gap_in    = (gap_ff != GapMax) ? gap_ff + 1'b1 : gap_ff;
      end
      elapsed_in = (elapsed_ff != ElapsedMax) ? elapsed_ff + 1'b1 : elapsed_ff;
      closing    = elapsed_in >= cfg.window_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulses_ff  <= '0;
         gap_ff     <= '0;
         elapsed_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            gap_ff <= gap_in;
            if (closing) begin
               pulses_ff  <= '0;
               elapsed_ff <= '0;
            end else begin
               pulses_ff  <= pulses_in;
               elapsed_ff <= elapsed_in;
            end
         end
         if (in_ready) begin
            valid_ff <= accept && closing;
         end
      end
   end

   // A count below the valid minimum reads as no flow at all.
   always_ff @(posedge clock) begin
      if (accept && closing) begin
         win_ff.count <= (pulses_in < cfg.min_valid_count) ? '0 : pulses_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_win   = win_ff;

   `FPWC_ASSERT_NEXT(a_close_clears, clock, reset, accept && closing,
      pulses_ff == '0 && elapsed_ff == '0)
   `FPWC_ASSERT_NEXT(a_pulse_restarts_gap, clock, reset, accept && counted,
      gap_ff == GapWidth'(1))

endmodule

`default_nettype wire

>>> src/fpwc_scale.sv
`default_nettype none

module fpwc_scale (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [fpwc_pkg::ScaleWidth-1:0]      flow_scale,
   input  wire logic                                 in_valid,
   output logic                                      in_ready,
   input  wire fpwc_pkg::win_type                    in_win,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output fpwc_pkg::flow_type                        out_flow
);
   import fpwc_pkg::*;

   `include "assert_macros.svh"

   logic [ProdWidth-1:0] product;
   logic                 saturate;
   logic                 valid_ff;
   flow_type             flow_ff;

   assign in_ready = !valid_ff || out_ready;

   // Q16 scale: keep the integer part and clamp anything above sixteen bits.
   always_comb begin
      product  = ProdWidth'(in_win.count) * ProdWidth'(flow_scale);
      saturate = |product[ProdWidth-1:FracBits+FlowWidth];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         flow_ff.flow  <= saturate ? FlowMax : product[FracBits+FlowWidth-1:FracBits];
         flow_ff.count <= in_win.count;
      end
   end

   assign out_valid = valid_ff;
   assign out_flow  = flow_ff;

   `FPWC_ASSERT_NOW(a_zero_count_zero_flow, clock, reset,
      valid_ff && flow_ff.count == '0, flow_ff.flow == '0)

endmodule

`default_nettype wire

>>> src/fpwc_class.sv
`default_nettype none

module fpwc_class (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fpwc_pkg::cfg_type                 cfg,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire fpwc_pkg::flow_type                in_flow,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [fpwc_pkg::FlowWidth-1:0]         out_flow_centi,
   output logic [fpwc_pkg::ClassWidth-1:0]        out_flow_class,
   output logic [fpwc_pkg::CountWidth-1:0]        out_pulse_count
);
   import fpwc_pkg::*;

   logic           valid_ff;
   flow_type       flow_ff;
   flow_class_type class_ff;
   flow_class_type class_in;

   assign in_ready = !valid_ff || out_ready;

   // The first threshold that the flow falls below decides the class.
   always_comb begin
      if (in_flow.flow < cfg.thr_no_flow) begin
         class_in = CLASS_NO_FLOW;
      end else if (in_flow.flow < cfg.thr_medium) begin
         class_in = CLASS_WEAK;
      end else if (in_flow.flow < cfg.thr_strong) begin
         class_in = CLASS_MEDIUM;
      end else begin
         class_in = CLASS_STRONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         flow_ff  <= in_flow;
         class_ff <= class_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_flow_centi  = flow_ff.flow;
   assign out_flow_class  = class_ff;
   assign out_pulse_count = flow_ff.count;

endmodule

`default_nettype wire

>>> src/flow_pulse_window_classifier.sv
// A window-closing word's result passes the counter, scale and class registers in turn.
// Throughput: one word per cycle unless stalled; the counters, the Q16 multiplier and
// the classifier each sit behind their own register, so the three stages overlap freely.
// Most words close no window, leaving no result; a stall holds full stages before it.
// Reset (synchronous, active high) clears the counters and every stage's valid flag,
// and loads each configuration register with its default value.
`default_nettype none

module flow_pulse_window_classifier (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Tick input: one word per microsecond of the time base.
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_sensor_rise,
   // Window result.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [fpwc_pkg::FlowWidth-1:0]           rsp_flow_centi,
   output logic [fpwc_pkg::ClassWidth-1:0]          rsp_flow_class,
   output logic [fpwc_pkg::CountWidth-1:0]          rsp_pulse_count,
   // Configuration writes.
   input  wire logic                                csr_wen,
   input  wire logic [fpwc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [fpwc_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import fpwc_pkg::*;

   cfg_type  cfg_ff;
   logic     win_valid;
   logic     win_ready;
   win_type  win;
   logic     flow_valid;
   logic     flow_ready;
   flow_type flow;

   // Configuration registers. Each write keeps only the low bits that the
   // register holds; an index beyond the list is simply ignored. Writes are
   // expected only while the pipeline is empty, so no stage guards against a
   // change under its feet.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_gap   <= RstMinPulseGap;
         cfg_ff.window_len      <= RstWindowLen;
         cfg_ff.min_valid_count <= RstMinValidCount;
         cfg_ff.flow_scale      <= RstFlowScale;
         cfg_ff.thr_no_flow     <= RstThrNoFlow;
         cfg_ff.thr_medium      <= RstThrMedium;
         cfg_ff.thr_strong      <= RstThrStrong;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MIN_PULSE_GAP: begin
               cfg_ff.min_pulse_gap <= csr_wdata[GapWidth-1:0];
            end
            CSR_WINDOW_LEN: begin
               cfg_ff.window_len <= csr_wdata[WindowWidth-1:0];
            end
            CSR_MIN_VALID_COUNT: begin
               cfg_ff.min_valid_count <= csr_wdata[CountWidth-1:0];
            end
            CSR_FLOW_SCALE: begin
               cfg_ff.flow_scale <= csr_wdata[ScaleWidth-1:0];
            end
            CSR_THR_NO_FLOW: begin
               cfg_ff.thr_no_flow <= csr_wdata[FlowWidth-1:0];
            end
            CSR_THR_MEDIUM: begin
               cfg_ff.thr_medium <= csr_wdata[FlowWidth-1:0];
            end
            CSR_THR_STRONG: begin
               cfg_ff.thr_strong <= csr_wdata[FlowWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage one: the pulse gap filter, the window timer and the pulse count.
   // Every accepted word advances them; only a word that closes the window
   // passes anything on, and an edge on that closing tick is still counted.
   fpwc_counter u_counter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_rise   (req_sensor_rise),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .out_win   (win)
   );

   // Stage two: the count times the Q16 scale, truncated and clamped.
   fpwc_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .flow_scale (cfg_ff.flow_scale),
      .in_valid   (win_valid),
      .in_ready   (win_ready),
      .in_win     (win),
      .out_valid  (flow_valid),
      .out_ready  (flow_ready),
      .out_flow   (flow)
   );

   // Stage three: the four-level class and the result register itself.
   fpwc_class u_class (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (flow_valid),
      .in_ready        (flow_ready),
      .in_flow         (flow),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_flow_centi  (rsp_flow_centi),
      .out_flow_class  (rsp_flow_class),
      .out_pulse_count (rsp_pulse_count)
   );

endmodule

`default_nettype wire

>>> bench/flow_pulse_window_classifier_tb.sv
`default_nettype none

module flow_pulse_window_classifier_tb;
   import fpwc_pkg::*;

   // Cycles with no word moving on either channel before the run is declared hung.
   // The longest correct quiet stretch is the deliberate receiver hold-off below.
   localparam int QuietLimit   = 2000;
   // Cycles allowed after the last expected result before the configuration may change.
   // The block's result passes its counter, scale and class registers, so this is ample.
   localparam int DrainCycles  = 8;
   // Length of the deliberate receiver hold-off, counted by the receiver process.
   localparam int PressureHold = 400;
   // Beyond this many mismatch lines, further mismatches are only counted.
   localparam int MaxReports   = 60;
   // An index that names no register; writes to it must change nothing.
   localparam logic [CsrIdxWidth-1:0] CsrUnusedIdx = 3'd7;

   // One closed window as it should appear on the result channel.
   typedef struct packed {
      logic [FlowWidth-1:0]  flow_centi;
      flow_class_type        flow_class;
      logic [CountWidth-1:0] pulse_count;
   } window_reading_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_sensor_rise = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [FlowWidth-1:0]    rsp_flow_centi;
   logic [ClassWidth-1:0]   rsp_flow_class;
   logic [CountWidth-1:0]   rsp_pulse_count;
   logic                    csr_wen = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // The predictor's own copy of the configuration and of the tick counters.
   cfg_type model_cfg = '{RstMinPulseGap, RstWindowLen, RstMinValidCount, RstFlowScale,
                          RstThrNoFlow, RstThrMedium, RstThrStrong};
   logic [CountWidth-1:0]  open_pulses  = '0;
   logic [GapWidth-1:0]    since_edge   = '0;
   logic [WindowWidth-1:0] open_elapsed = '0;

   // Readings still owed by the block, oldest first.
   window_reading_type pending_readings[$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // Idling of both sides, in cycles out of a hundred; the random traffic test sets these per mode.
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   // The test raises hold_requests to ask for one long hold-off; the receiver process
   // notices the change and counts the hold-off out on its own.
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   flow_pulse_window_classifier dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sensor_rise (req_sensor_rise),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_flow_centi  (rsp_flow_centi),
      .rsp_flow_class  (rsp_flow_class),
      .rsp_pulse_count (rsp_pulse_count),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   // Advances the predicted counters by one tick. When the tick closes the window,
   // the reading it should produce is queued.
   task automatic account_tick(input logic rise);
      logic [CountWidth-1:0] count;
      logic [ProdWidth-1:0]  product;
      window_reading_type    reading;
      // A qualified edge restarts the gap count at one; the counters saturate.
      if (rise && since_edge >= model_cfg.min_pulse_gap) begin
         if (open_pulses != CountMax) begin
            open_pulses = open_pulses + 1'b1;
         end
         since_edge = GapWidth'(1);
      end else if (since_edge != GapMax) begin
         since_edge = since_edge + 1'b1;
      end
      if (open_elapsed != ElapsedMax) begin
         open_elapsed = open_elapsed + 1'b1;
      end
      // An edge on the closing tick has already been added above, so it joins this window.
      if (open_elapsed >= model_cfg.window_len) begin
         count = open_pulses;
         open_pulses = '0;
         open_elapsed = '0;
         if (count < model_cfg.min_valid_count) begin
            count = '0;
         end
         product = ProdWidth'(count) * ProdWidth'(model_cfg.flow_scale);
         product = product >> FracBits;
         reading.flow_centi  = (product > FlowMax) ? FlowMax : product[FlowWidth-1:0];
         reading.pulse_count = count;
         // Thresholds are tried in this fixed order, so they need not be ascending.
         if (reading.flow_centi < model_cfg.thr_no_flow) begin
            reading.flow_class = CLASS_NO_FLOW;
         end else if (reading.flow_centi < model_cfg.thr_medium) begin
            reading.flow_class = CLASS_WEAK;
         end else if (reading.flow_centi < model_cfg.thr_strong) begin
            reading.flow_class = CLASS_MEDIUM;
         end else begin
            reading.flow_class = CLASS_STRONG;
         end
         pending_readings.push_back(reading);
      end
   endtask

   task automatic check_reading();
      window_reading_type want;
      if (pending_readings.size() == 0) begin
         report_mismatch($sformatf("reading with none owed: flow %0d class %0d count %0d",
                                   rsp_flow_centi, rsp_flow_class, rsp_pulse_count));
      end else begin
         want = pending_readings.pop_front();
         if (rsp_flow_centi !== want.flow_centi) begin
            report_mismatch($sformatf("flow_centi %0d, expected %0d",
                                      rsp_flow_centi, want.flow_centi));
         end
         if (rsp_flow_class !== want.flow_class) begin
            report_mismatch($sformatf("flow_class %0d, expected %0d",
                                      rsp_flow_class, want.flow_class));
         end
         if (rsp_pulse_count !== want.pulse_count) begin
            report_mismatch($sformatf("pulse_count %0d, expected %0d",
                                      rsp_pulse_count, want.pulse_count));
         end
      end
   endtask

   // Both channels are sampled at the rising edge, before any of that edge's updates land,
   // so a word counts as moved exactly when valid and ready were both high going into it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_reading();
         end
         if (req_valid && req_ready) begin
            account_tick(req_sensor_rise);
         end
      end
   end

   // Receiver: random stalls at the phase's rate, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = PressureHold;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Watchdog: a run in which no word moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("flow_pulse_window_classifier regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Writes one register and mirrors the write in the predictor. Only called while idle.
   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_MIN_PULSE_GAP:   model_cfg.min_pulse_gap   = data[GapWidth-1:0];
         CSR_WINDOW_LEN:      model_cfg.window_len      = data[WindowWidth-1:0];
         CSR_MIN_VALID_COUNT: model_cfg.min_valid_count = data[CountWidth-1:0];
         CSR_FLOW_SCALE:      model_cfg.flow_scale      = data[ScaleWidth-1:0];
         CSR_THR_NO_FLOW:     model_cfg.thr_no_flow     = data[FlowWidth-1:0];
         CSR_THR_MEDIUM:      model_cfg.thr_medium      = data[FlowWidth-1:0];
         CSR_THR_STRONG:      model_cfg.thr_strong      = data[FlowWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CsrDataWidth-1:0] gap,
                                 input logic [CsrDataWidth-1:0] len,
                                 input logic [CsrDataWidth-1:0] min_count,
                                 input logic [CsrDataWidth-1:0] scale,
                                 input logic [CsrDataWidth-1:0] thr_none,
                                 input logic [CsrDataWidth-1:0] thr_mid,
                                 input logic [CsrDataWidth-1:0] thr_high);
      write_csr(CSR_MIN_PULSE_GAP, gap);
      write_csr(CSR_WINDOW_LEN, len);
      write_csr(CSR_MIN_VALID_COUNT, min_count);
      write_csr(CSR_FLOW_SCALE, scale);
      write_csr(CSR_THR_NO_FLOW, thr_none);
      write_csr(CSR_THR_MEDIUM, thr_mid);
      write_csr(CSR_THR_STRONG, thr_high);
   endtask

   // Offers one tick word and returns once ready reads high after an edge. Valid is left high so
   // that back-to-back words keep it high; an idle cycle lowers it first.
   task automatic send_tick(input logic rise);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sensor_rise <= rise;
      do @(posedge clock); while (!req_ready);
   endtask

   // Ends a phase: stops offering, waits for every owed reading, then lets the pipeline
   // settle, since the last ticks may still be in flight without owing anything.
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Straight after reset the gap counter is zero, so with the default minimum gap the
   // edge on the very first tick must not count. The default window stays open here.
   task automatic test_start_of_time();
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      finish_phase();
   endtask

   // Window mechanics: a zero length closes on every tick, the minimum gap filters edges,
   // an edge on the closing tick joins its window, and short counts are forced to zero.
   task automatic test_window_closing();
      apply_settings(0, 0, 0, 32'h0001_0000, 1, 2, 3);
      write_csr(CsrUnusedIdx, '1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      finish_phase();
      apply_settings(2, 3, 2, 32'h0002_0000, 1, 4, 6);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      finish_phase();
   endtask

   // Flow arithmetic and classes: saturation of the flow, thresholds out of order, and the
   // register extremes (longest window, largest minimum count, zero scale, zero thresholds).
   task automatic test_flow_classes();
      apply_settings(0, 2, 0, 32'hFFFF_FFFF, 32'h0000_FFFF, 0, 0);
      send_tick(1'b1);
      send_tick(1'b1);
      finish_phase();
      apply_settings(0, 1, 0, 32'h0007_0000, 5, 100, 10);
      send_tick(1'b1);
      send_tick(1'b0);
      finish_phase();
      apply_settings(0, 32'h00FF_FFFF, 32'h0000_FFFF, 0, 0, 0, 0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      finish_phase();
      // Shortening the window closes it on the next tick, with its pulses held so far.
      write_csr(CSR_WINDOW_LEN, 1);
      send_tick(1'b1);
      finish_phase();
   endtask

   // One reading per tick while the receiver holds off: the pipeline fills and the
   // block has to stall its input until the receiver comes back.
   task automatic test_back_pressure();
      apply_settings(0, 1, 0, 32'h0064_0000, 50, 100, 200);
      hold_requests <= hold_requests + 1;
      repeat (60) send_tick(1'($urandom_range(0, 1)));
      finish_phase();
   endtask

   // Draws a fresh configuration: short windows so readings come often, scales and
   // thresholds chosen so that every class turns up, now and then wild values.
   task automatic randomise_settings();
      logic [CsrDataWidth-1:0] len;
      logic [CsrDataWidth-1:0] scale;
      logic [CsrDataWidth-1:0] thr_none;
      logic [CsrDataWidth-1:0] thr_mid;
      logic [CsrDataWidth-1:0] thr_high;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 24);
      if ($urandom_range(0, 3) == 0) begin
         scale = $urandom();
      end else begin
         scale = ($urandom_range(0, 400) << 16) | $urandom_range(0, 65535);
      end
      if ($urandom_range(0, 7) == 0) begin
         thr_none = $urandom_range(0, 65535);
         thr_mid  = $urandom_range(0, 65535);
         thr_high = $urandom_range(0, 65535);
      end else begin
         thr_none = $urandom_range(0, 1500);
         thr_mid  = thr_none + $urandom_range(0, 2000);
         thr_high = thr_mid + $urandom_range(0, 3000);
      end
      apply_settings($urandom_range(0, 6), len, $urandom_range(0, 4), scale,
                     thr_none, thr_mid, thr_high);
   endtask

   // Mostly regular pulse trains whose period wanders around the minimum gap, so edges
   // land just before, on and just after the limit; one tick in five is random noise.
   task automatic send_pulse_trains(input int items);
      int   period;
      int   pos;
      logic rise;
      period = 1;
      pos    = 0;
      repeat (items) begin
         if ($urandom_range(0, 4) == 0) begin
            rise = 1'($urandom_range(0, 1));
         end else begin
            rise = (pos == 0);
         end
         pos++;
         if (pos >= period) begin
            pos    = 0;
            period = int'(model_cfg.min_pulse_gap) + int'($urandom_range(0, 3)) - 1;
            if (period < 1) begin
               period = 1;
            end
         end
         send_tick(rise);
      end
   endtask

   // Random traffic through each idling pattern, two configurations apiece.
   task automatic test_random_traffic();
      int sender_idle[4]    = '{0, 61, 0, 8};
      int receiver_stall[4] = '{0, 0, 61, 8};
      for (int mode = 0; mode < 4; mode++) begin
         sender_idle_pct = sender_idle[mode];
         rsp_stall_pct   = receiver_stall[mode];
         repeat (2) begin
            randomise_settings();
            send_pulse_trains(70);
            finish_phase();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_start_of_time();
      test_window_closing();
      test_flow_classes();
      test_back_pressure();
      test_random_traffic();
      if (mismatch_count == 0) begin
         $display("flow_pulse_window_classifier regression: pass");
      end else begin
         $display("flow_pulse_window_classifier regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
